// File: hdl/hsv_pkg.sv
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SEXT_W  = 3;
  localparam int unsigned FRAC_W  = 6;
  localparam int unsigned BASE_W  = 15;
  localparam int unsigned COEF_W  = 13;
  localparam int unsigned PROD_W  = 28;
  localparam int unsigned RECIP_W = 29;
  localparam int unsigned QUOT_W  = PROD_W + RECIP_W;

  localparam logic [HUE_W-1:0]  HUE_MAX = 9'd359;
  localparam logic [PCT_W-1:0]  PCT_MAX = 7'd100;
  localparam logic [COEF_W-1:0] SEXT_DEG = 13'd60;
  localparam logic [COEF_W-1:0] K_PEAK = 13'd6000;

  // Reciprocal of 600000 scaled by 2^48; exact for every product below 2^28.
  localparam logic [RECIP_W-1:0] RECIP = 29'd469124962;
  localparam int unsigned RECIP_SHIFT = 48;

  localparam logic [SEXT_W-1:0] SEXT_0 = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_5 = 3'd5;

  typedef struct packed {
    logic [SEXT_W-1:0] sector;
    logic [BASE_W-1:0] base;
    logic [COEF_W-1:0] k_floor;
    logic [COEF_W-1:0] k_up;
    logic [COEF_W-1:0] k_down;
  } coef_t;

  typedef struct packed {
    logic [SEXT_W-1:0] sector;
    logic [CHAN_W-1:0] peak;
    logic [CHAN_W-1:0] floor_l;
    logic [CHAN_W-1:0] up;
    logic [CHAN_W-1:0] down;
  } level_t;

endpackage

// File: hdl/hsv_prep.sv
`timescale 1ns / 1ps

module hsv_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hsv_pkg::HUE_W-1:0]     hue,
  input  logic [hsv_pkg::PCT_W-1:0]     saturation,
  input  logic [hsv_pkg::PCT_W-1:0]     brightness,
  output logic                          coef_valid,
  output hsv_pkg::coef_t                coef
);

  logic [hsv_pkg::HUE_W-1:0]  h_c;
  logic [hsv_pkg::PCT_W-1:0]  s_c;
  logic [hsv_pkg::PCT_W-1:0]  v_c;
  logic [hsv_pkg::SEXT_W-1:0] sec_nxt;
  logic [hsv_pkg::HUE_W-1:0]  start_deg;
  logic [hsv_pkg::FRAC_W-1:0] frac_nxt;
  logic [hsv_pkg::BASE_W-1:0] base_nxt;

  logic                       v1_r;
  logic [hsv_pkg::SEXT_W-1:0] sec_r;
  logic [hsv_pkg::FRAC_W-1:0] frac_r;
  logic [hsv_pkg::PCT_W-1:0]  sat_r;
  logic [hsv_pkg::BASE_W-1:0] base_r;

  logic [hsv_pkg::COEF_W-1:0] sf;
  logic [hsv_pkg::COEF_W-1:0] k_floor_nxt;
  logic                       v2_r;
  hsv_pkg::coef_t             coef_r;

  always_comb begin
    h_c = (hue > hsv_pkg::HUE_MAX) ? hsv_pkg::HUE_MAX : hue;
    s_c = (saturation > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : saturation;
    v_c = (brightness > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : brightness;
    sec_nxt = hsv_pkg::SEXT_0;
    start_deg = 9'd0;
    if (h_c >= 9'd60) begin
      sec_nxt = hsv_pkg::SEXT_1;
      start_deg = 9'd60;
    end
    if (h_c >= 9'd120) begin
      sec_nxt = hsv_pkg::SEXT_2;
      start_deg = 9'd120;
    end
    if (h_c >= 9'd180) begin
      sec_nxt = hsv_pkg::SEXT_3;
      start_deg = 9'd180;
    end
    if (h_c >= 9'd240) begin
      sec_nxt = hsv_pkg::SEXT_4;
      start_deg = 9'd240;
    end
    if (h_c >= 9'd300) begin
      sec_nxt = hsv_pkg::SEXT_5;
      start_deg = 9'd300;
    end
    frac_nxt = hsv_pkg::FRAC_W'(h_c - start_deg);
    base_nxt = (hsv_pkg::BASE_W'(v_c) << 8) - hsv_pkg::BASE_W'(v_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      sec_r  <= sec_nxt;
      frac_r <= frac_nxt;
      sat_r  <= s_c;
      base_r <= base_nxt;
    end
  end

  always_comb begin
    sf = hsv_pkg::COEF_W'(sat_r) * hsv_pkg::COEF_W'(frac_r);
    k_floor_nxt = hsv_pkg::COEF_W'(hsv_pkg::PCT_MAX - sat_r) * hsv_pkg::SEXT_DEG;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      coef_r.sector  <= sec_r;
      coef_r.base    <= base_r;
      coef_r.k_floor <= k_floor_nxt;
      coef_r.k_up    <= k_floor_nxt + sf;
      coef_r.k_down  <= hsv_pkg::K_PEAK - sf;
    end
  end

  assign coef_valid = v2_r;
  assign coef       = coef_r;

endmodule

// File: hdl/hsv_scale.sv
`timescale 1ns / 1ps

module hsv_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            coef_valid,
  input  hsv_pkg::coef_t  coef,
  output logic            lvl_valid,
  output hsv_pkg::level_t lvl
);

  localparam int unsigned NLANE = 4;

  logic [hsv_pkg::COEF_W-1:0] k   [NLANE];
  logic                       v3_r;
  logic [hsv_pkg::SEXT_W-1:0] sec3_r;
  logic [hsv_pkg::PROD_W-1:0] prod_r [NLANE];
  logic [hsv_pkg::QUOT_W-1:0] quot [NLANE];
  logic                       v4_r;
  hsv_pkg::level_t            lvl_r;

  assign k[0] = hsv_pkg::K_PEAK;
  assign k[1] = coef.k_floor;
  assign k[2] = coef.k_up;
  assign k[3] = coef.k_down;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= coef_valid;
    end
    if (en) begin
      sec3_r <= coef.sector;
      for (int i = 0; i < NLANE; i++) begin
        prod_r[i] <= hsv_pkg::PROD_W'(coef.base) * hsv_pkg::PROD_W'(k[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      quot[i] = hsv_pkg::QUOT_W'(prod_r[i]) * hsv_pkg::QUOT_W'(hsv_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      lvl_r.sector  <= sec3_r;
      lvl_r.peak    <= quot[0][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CHAN_W];
      lvl_r.floor_l <= quot[1][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CHAN_W];
      lvl_r.up      <= quot[2][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CHAN_W];
      lvl_r.down    <= quot[3][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CHAN_W];
    end
  end

  assign lvl_valid = v4_r;
  assign lvl       = lvl_r;

endmodule

// File: hdl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSV to RGB color converter for a pixel stream.
// The input channel (in_valid, in_stall, in_hue, in_saturation, in_brightness)
// takes one transaction per clock when in_stall is low. Out-of-range hue,
// saturation and brightness are clamped to 359, 100 and 100.
// The result channel (out_valid, out_stall, out_red, out_green, out_blue)
// presents one color per transaction, 8 bits per channel, each channel
// truncated toward zero. One transaction per cycle is sustained while no
// valid result is stalled, through a five-stage pipeline: clamp and
// sextant split, coefficient forming, level products, reciprocal scaling,
// and channel selection into the output register.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; the held result stays unchanged and no
// transaction is lost or repeated.
// A synchronous reset on rst_n clears all valid bits; the block accepts a
// transaction in the first cycle after reset.
module hsv_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsv_pkg::HUE_W-1:0]     in_hue,
  input  logic [hsv_pkg::PCT_W-1:0]     in_saturation,
  input  logic [hsv_pkg::PCT_W-1:0]     in_brightness,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsv_pkg::CHAN_W-1:0]    out_red,
  output logic [hsv_pkg::CHAN_W-1:0]    out_green,
  output logic [hsv_pkg::CHAN_W-1:0]    out_blue
);

  logic                       en;
  logic                       coef_valid;
  hsv_pkg::coef_t             coef;
  logic                       lvl_valid;
  hsv_pkg::level_t            lvl;
  logic [hsv_pkg::CHAN_W-1:0] red_nxt;
  logic [hsv_pkg::CHAN_W-1:0] green_nxt;
  logic [hsv_pkg::CHAN_W-1:0] blue_nxt;
  logic                       out_valid_r;
  logic [hsv_pkg::CHAN_W-1:0] red_r;
  logic [hsv_pkg::CHAN_W-1:0] green_r;
  logic [hsv_pkg::CHAN_W-1:0] blue_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  hsv_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .coef_valid (coef_valid),
    .coef       (coef)
  );

  hsv_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .coef_valid (coef_valid),
    .coef       (coef),
    .lvl_valid  (lvl_valid),
    .lvl        (lvl)
  );

  always_comb begin
    case (lvl.sector)
      hsv_pkg::SEXT_0: begin
        red_nxt = lvl.peak;    green_nxt = lvl.up;      blue_nxt = lvl.floor_l;
      end
      hsv_pkg::SEXT_1: begin
        red_nxt = lvl.down;    green_nxt = lvl.peak;    blue_nxt = lvl.floor_l;
      end
      hsv_pkg::SEXT_2: begin
        red_nxt = lvl.floor_l; green_nxt = lvl.peak;    blue_nxt = lvl.up;
      end
      hsv_pkg::SEXT_3: begin
        red_nxt = lvl.floor_l; green_nxt = lvl.down;    blue_nxt = lvl.peak;
      end
      hsv_pkg::SEXT_4: begin
        red_nxt = lvl.up;      green_nxt = lvl.floor_l; blue_nxt = lvl.peak;
      end
      default: begin
        red_nxt = lvl.peak;    green_nxt = lvl.floor_l; blue_nxt = lvl.down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lvl_valid;
    end
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// File: hdl/hsv_checker.sv
`timescale 1ns / 1ps

module hsv_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hsv_pkg::CHAN_W-1:0]    out_red,
  input logic [hsv_pkg::CHAN_W-1:0]    out_green,
  input logic [hsv_pkg::CHAN_W-1:0]    out_blue
);

  // A stalled result must hold its color until the transaction completes.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  // The input side is only held back by a stalled valid result.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted transaction appears at out_valid when nothing stalls.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
